>>> hdl/dbam_pkg.sv
// ============================================================================
// dbam_pkg
// Shared types and constants for the disk block availability map.
// ============================================================================
package dbam_pkg;

    // Operation codes carried in the operation field of an item.
    localparam logic [2:0] OP_QUERY = 3'd0;
    localparam logic [2:0] OP_ALLOC = 3'd1;
    localparam logic [2:0] OP_FREE  = 3'd2;
    localparam logic [2:0] OP_TOTAL = 3'd3;
    localparam logic [2:0] OP_LOAD  = 3'd4;

    // Register index of the format register on the configuration port.
    localparam logic REG_DISK_FORMAT = 1'b0;

    // Limits of the small format.
    localparam int SMALL_TRACKS  = 35;
    localparam int SMALL_SECTORS = 24;

    // Field widths fixed by the item layout.
    localparam int OP_W     = 3;
    localparam int TRACK_W  = 7;
    localparam int SECTOR_W = 6;
    localparam int COUNT_W  = 8;
    localparam int LOAD_W   = 40;
    localparam int TOTAL_W  = 15;
    localparam int TRK_CW   = 8;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [TRACK_W-1:0]  track;
        logic [SECTOR_W-1:0] sector;
        logic [COUNT_W-1:0]  load_count;
        logic [LOAD_W-1:0]   load_bitmap;
    } req_t;

    typedef struct packed {
        logic               success;
        logic [TOTAL_W-1:0] free_total;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SUM,
        ST_SUM_LAST
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic update;
        logic sum_issue;
        logic sum_done;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_total;
        logic cnt_last;
    } ctrl_sts_t;

endpackage

>>> hdl/disk_block_availability_map_top.sv
// ============================================================================
// disk_block_availability_map_top
// Per-track sector allocation map with query, allocate, free, load and
// total free count operations.
// ============================================================================
//
//  Channel   Handshake                       Payload
//  --------  ------------------------------  ----------------------------------
//  request   start, accepted when busy low   req (operation, track, sector, ...)
//  result    done, one-cycle strobe          rsp (success, free_total)
//  config    APB, psel/penable/pwrite        pwdata[0] -> disk_format
//
//  Query, allocate, free and load raise busy for a single update state and
//  register their result from it; a new item is taken only back in idle.
//  The total count walks the active tracks through the entry RAM read port,
//  one track a cycle, and keeps busy high until the sum is registered.
//  Reset clears the per-entry valid bits at once; no clearing pass is run.
//  The receiver cannot stall: each result is shown for exactly one cycle.
//
module disk_block_availability_map_top #(
    parameter int MAX_TRACKS      = 80,
    parameter int MAX_SECTOR_BITS = 40
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  dbam_pkg::req_t  req,
    output logic            done,
    output dbam_pkg::rsp_t  rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic                 format_reg;
    logic                 reg_hit;
    dbam_pkg::ctrl_cmd_t  cmd;
    dbam_pkg::ctrl_sts_t  sts;

    assign reg_hit = (paddr[2] == dbam_pkg::REG_DISK_FORMAT);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {31'b0, format_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            format_reg <= pwdata[0];
        end
    end

    dbam_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    dbam_dp #(
        .MAX_TRACKS      (MAX_TRACKS),
        .MAX_SECTOR_BITS (MAX_SECTOR_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .disk_format (format_reg),
        .req         (req),
        .cmd         (cmd),
        .sts         (sts),
        .done        (done),
        .rsp         (rsp)
    );

endmodule

>>> hdl/dbam_ram.sv
// ============================================================================
// dbam_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module dbam_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/dbam_ctrl.sv
// ============================================================================
// dbam_ctrl
// Controller state machine: sequences single-entry updates and the
// track walk of the total count.
// ============================================================================
module dbam_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  dbam_pkg::ctrl_sts_t  sts,
    output dbam_pkg::ctrl_cmd_t  cmd,
    output logic                 busy
);

    dbam_pkg::state_t state_reg;
    dbam_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dbam_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dbam_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = sts.is_total ? dbam_pkg::ST_SUM : dbam_pkg::ST_UPDATE;
                end
            end
            dbam_pkg::ST_UPDATE:
            begin
                state_next = dbam_pkg::ST_IDLE;
            end
            dbam_pkg::ST_SUM:
            begin
                if (sts.cnt_last)
                begin
                    state_next = dbam_pkg::ST_SUM_LAST;
                end
            end
            dbam_pkg::ST_SUM_LAST:
            begin
                state_next = dbam_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dbam_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            dbam_pkg::ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
            end
            dbam_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            dbam_pkg::ST_SUM:
            begin
                cmd.sum_issue = 1'b1;
            end
            dbam_pkg::ST_SUM_LAST:
            begin
                cmd.sum_done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

>>> hdl/dbam_dp.sv
// ============================================================================
// dbam_dp
// Datapath: request registers, track entry RAM with valid bits,
// read-modify-write logic, walk counter and free count accumulator.
// ============================================================================
module dbam_dp #(
    parameter int MAX_TRACKS      = 80,
    parameter int MAX_SECTOR_BITS = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 disk_format,
    input  dbam_pkg::req_t       req,
    input  dbam_pkg::ctrl_cmd_t  cmd,
    output dbam_pkg::ctrl_sts_t  sts,
    output logic                 done,
    output dbam_pkg::rsp_t       rsp
);

    localparam int AW = $clog2(MAX_TRACKS);
    localparam int SW = MAX_SECTOR_BITS;
    localparam int CW = dbam_pkg::COUNT_W;
    localparam int EW = SW + CW;
    localparam int XW = SW + dbam_pkg::LOAD_W;

    // Request registers
    logic [dbam_pkg::OP_W-1:0] op_reg;
    logic                      trk_ok_reg;
    logic                      sec_ok_reg;
    logic [AW-1:0]             idx_reg;
    logic [dbam_pkg::SECTOR_W-1:0] sec_reg;
    logic [CW-1:0]             lcount_reg;
    logic [SW-1:0]             lbitmap_reg;

    // Walk state
    logic [AW-1:0]             cnt_reg;
    logic                      pend_reg;
    logic [dbam_pkg::TOTAL_W-1:0] acc_reg;

    // Entry valid bits and registered read
    logic [MAX_TRACKS-1:0]     valid_reg;
    logic                      rd_vld_reg;
    logic [EW-1:0]             ram_rdata;

    logic                      done_reg;
    dbam_pkg::rsp_t            rsp_reg;

    logic [dbam_pkg::TRK_CW-1:0] trk_lim;
    logic                      in_trk_ok;
    logic                      in_sec_ok;
    logic [AW-1:0]             in_idx;
    logic [AW-1:0]             raddr;
    logic [AW-1:0]             last_idx;
    logic [dbam_pkg::SECTOR_W:0] sec_lim;
    logic [SW-1:0]             sec_mask;
    logic [XW-1:0]             load_ext;
    logic [SW-1:0]             entry_bm;
    logic [CW-1:0]             entry_cnt;
    logic [SW-1:0]             bit_mask;
    logic                      is_free;
    logic                      hit_ok;
    logic                      wr_ok;
    logic                      we;
    logic [SW-1:0]             new_bm;
    logic [CW-1:0]             new_cnt;
    logic [dbam_pkg::TOTAL_W-1:0] sum_final;

    assign trk_lim  = disk_format ? dbam_pkg::TRK_CW'(MAX_TRACKS)
                                  : dbam_pkg::TRK_CW'(dbam_pkg::SMALL_TRACKS);
    assign last_idx = disk_format ? AW'(MAX_TRACKS - 1) : AW'(dbam_pkg::SMALL_TRACKS - 1);
    assign sec_lim  = disk_format ? (dbam_pkg::SECTOR_W + 1)'(MAX_SECTOR_BITS)
                                  : (dbam_pkg::SECTOR_W + 1)'(dbam_pkg::SMALL_SECTORS);
    assign sec_mask = disk_format ? {SW{1'b1}} : SW'({dbam_pkg::SMALL_SECTORS{1'b1}});

    assign in_trk_ok = (req.track != '0) && ({1'b0, req.track} <= trk_lim);
    assign in_sec_ok = {1'b0, req.sector} < sec_lim;
    assign in_idx    = in_trk_ok ? AW'(req.track - dbam_pkg::TRACK_W'(1)) : '0;
    assign load_ext  = {SW'(0), req.load_bitmap};
    assign raddr     = cmd.sum_issue ? cnt_reg : in_idx;

    assign sts.is_total = (req.operation == dbam_pkg::OP_TOTAL);
    assign sts.cnt_last = (cnt_reg == last_idx);

    // An entry never written since reset reads as all allocated with count zero.
    assign entry_bm  = rd_vld_reg ? ram_rdata[SW-1:0] : '0;
    assign entry_cnt = rd_vld_reg ? ram_rdata[EW-1:SW] : '0;
    assign bit_mask  = SW'(1) << sec_reg;
    assign is_free   = |(entry_bm & bit_mask);
    assign hit_ok    = trk_ok_reg && sec_ok_reg;
    assign sum_final = acc_reg + dbam_pkg::TOTAL_W'(entry_cnt);

    always_comb
    begin
        wr_ok   = 1'b0;
        new_bm  = entry_bm;
        new_cnt = entry_cnt;
        unique case (op_reg)
            dbam_pkg::OP_ALLOC:
            begin
                wr_ok   = hit_ok && is_free;
                new_bm  = entry_bm & ~bit_mask;
                new_cnt = entry_cnt - CW'(1);
            end
            dbam_pkg::OP_FREE:
            begin
                wr_ok   = hit_ok && !is_free;
                new_bm  = entry_bm | bit_mask;
                new_cnt = entry_cnt + CW'(1);
            end
            dbam_pkg::OP_LOAD:
            begin
                wr_ok   = trk_ok_reg;
                new_bm  = lbitmap_reg;
                new_cnt = lcount_reg;
            end
            default:
            begin
                wr_ok = 1'b0;
            end
        endcase
    end

    assign we = cmd.update && wr_ok;

    dbam_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TRACKS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (idx_reg),
        .wdata ({new_cnt, new_bm}),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg      <= req.operation;
            trk_ok_reg  <= in_trk_ok;
            sec_ok_reg  <= in_sec_ok;
            idx_reg     <= in_idx;
            sec_reg     <= req.sector;
            lcount_reg  <= req.load_count;
            lbitmap_reg <= load_ext[SW-1:0] & sec_mask;
        end
        if (cmd.accept)
        begin
            cnt_reg <= '0;
            acc_reg <= '0;
        end
        else if (cmd.sum_issue)
        begin
            cnt_reg <= cnt_reg + AW'(1);
            if (pend_reg)
            begin
                acc_reg <= sum_final;
            end
        end
        if (cmd.update)
        begin
            rsp_reg.success    <= wr_ok || (op_reg == dbam_pkg::OP_QUERY && hit_ok && is_free);
            rsp_reg.free_total <= '0;
        end
        else if (cmd.sum_done)
        begin
            rsp_reg.success    <= 1'b1;
            rsp_reg.free_total <= sum_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[raddr];
            pend_reg   <= cmd.sum_issue;
            done_reg   <= cmd.update || cmd.sum_done;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> hdl/dbam_checker.sv
// ============================================================================
// dbam_checker
// Port-level checks of request sequencing and result strobes.
// ============================================================================
module dbam_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic            done,
    input  dbam_pkg::rsp_t  rsp
);

    // An accepted item always raises busy in the cycle after its acceptance.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // Results are shown only once the block has returned to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // A result always follows a busy cycle, never an idle one.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !done)
        else $error("result strobe without work in progress");

    // A nonzero total only comes with a successful total count.
    a_total_success: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.free_total != '0 |-> rsp.success)
        else $error("nonzero total without success");

endmodule

bind disk_block_availability_map_top dbam_checker u_dbam_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
